/* rtl/core/hc3_pkg.sv */
// ----------------------------------------------------------------------------
// hc3_pkg
// Shared types, constants and mod-26 helpers for the 3x3 hill cipher unit.
// ----------------------------------------------------------------------------
package hc3_pkg;

  localparam int MODULUS = 26;
  localparam logic [4:0] PAD_LETTER = 5'd23;

  typedef logic [4:0] letter_t;
  typedef letter_t [8:0] matrix_t;
  typedef logic [2:0][14:0] key_rows_t;

  localparam logic [1:0] REG_KEY_ROW_0   = 2'd0;
  localparam logic [1:0] REG_KEY_ROW_1   = 2'd1;
  localparam logic [1:0] REG_KEY_ROW_2   = 2'd2;
  localparam logic [1:0] REG_CIPHER_MODE = 2'd3;

  localparam key_rows_t KEY_RESET = {15'd15924, 15'd10765, 15'd1798};

  // inverse of the reset key, entry r*3+c
  localparam matrix_t INV_RESET = {5'd8, 5'd12, 5'd21,
                                   5'd21, 5'd8, 5'd21,
                                   5'd10, 5'd5, 5'd8};

  typedef struct packed {
    letter_t [2:0] letters;
    logic          last;
  } block_t;

  typedef struct packed {
    letter_t letter;
    logic    block_end;
    logic    message_end;
    logic    key_error;
  } result_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } inv_status_t;

  // cofactor term: k[a0]*k[a1] - k[b0]*k[b1]
  typedef struct packed {
    logic [3:0] a0;
    logic [3:0] a1;
    logic [3:0] b0;
    logic [3:0] b1;
  } cof_idx_t;

  function automatic letter_t reduce_letter(input letter_t v);
    return (v >= letter_t'(MODULUS)) ? letter_t'(v - letter_t'(MODULUS)) : v;
  endfunction

  // restoring reduction, valid for v below 26 * 128
  function automatic letter_t mod26(input logic [11:0] v);
    logic [11:0] r;
    r = v;
    for (int k = 6; k >= 0; k--) begin
      if (r >= (12'(MODULUS) << k)) begin
        r = r - (12'(MODULUS) << k);
      end
    end
    return r[4:0];
  endfunction

  function automatic letter_t det_inverse(input letter_t d);
    letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic cof_idx_t cof_index(input logic [3:0] n);
    cof_idx_t c;
    case (n)
      4'd0:    c = '{a0: 4'd4, a1: 4'd8, b0: 4'd5, b1: 4'd7};
      4'd1:    c = '{a0: 4'd2, a1: 4'd7, b0: 4'd1, b1: 4'd8};
      4'd2:    c = '{a0: 4'd1, a1: 4'd5, b0: 4'd2, b1: 4'd4};
      4'd3:    c = '{a0: 4'd5, a1: 4'd6, b0: 4'd3, b1: 4'd8};
      4'd4:    c = '{a0: 4'd0, a1: 4'd8, b0: 4'd2, b1: 4'd6};
      4'd5:    c = '{a0: 4'd2, a1: 4'd3, b0: 4'd0, b1: 4'd5};
      4'd6:    c = '{a0: 4'd3, a1: 4'd7, b0: 4'd4, b1: 4'd6};
      4'd7:    c = '{a0: 4'd1, a1: 4'd6, b0: 4'd0, b1: 4'd7};
      4'd8:    c = '{a0: 4'd0, a1: 4'd4, b0: 4'd1, b1: 4'd3};
      default: c = '{a0: 4'd0, a1: 4'd0, b0: 4'd0, b1: 4'd0};
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/hc3_front.sv */
// ----------------------------------------------------------------------------
// hc3_front
// Collects letters into blocks of three, pads a block closed by a last item.
// ----------------------------------------------------------------------------
module hc3_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hc3_pkg::letter_t  letter,
  input  logic              last,
  input  logic              stall,
  input  logic              q_full,
  output logic              full,
  output logic              q_push,
  output hc3_pkg::block_t   q_block
);

  logic [1:0]       count;
  hc3_pkg::letter_t held [2];
  logic             accept;
  logic             closes;

  assign full   = q_full || stall;
  assign accept = push && !full;
  assign closes = last || (count == 2'd2);
  assign q_push = accept && closes;

  always_comb begin
    q_block.last       = last;
    q_block.letters[0] = (count == 2'd0) ? letter : held[0];
    q_block.letters[1] = (count == 2'd0) ? hc3_pkg::PAD_LETTER :
                         (count == 2'd1) ? letter : held[1];
    q_block.letters[2] = (count == 2'd2) ? letter : hc3_pkg::PAD_LETTER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      if (closes) begin
        count <= 2'd0;
      end else begin
        held[count[0]] <= letter;
        count          <= count + 2'd1;
      end
    end
  end

endmodule

/* rtl/core/hc3_block_queue.sv */
// ----------------------------------------------------------------------------
// hc3_block_queue
// Two-entry queue of letter blocks between the front and the back.
// ----------------------------------------------------------------------------
module hc3_block_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hc3_pkg::block_t din,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output hc3_pkg::block_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  hc3_pkg::block_t    mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [PTR_W:0]     count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == (PTR_W + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end
  end

endmodule

/* rtl/core/hc3_inverse.sv */
// ----------------------------------------------------------------------------
// hc3_inverse
// Sequencer that forms the mod-26 inverse key from the adjugate and the
// determinant inverse, one cofactor or product per cycle.
// ----------------------------------------------------------------------------
module hc3_inverse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  hc3_pkg::key_rows_t   key_rows,
  output hc3_pkg::matrix_t     inv_key,
  output hc3_pkg::inv_status_t status
);

  typedef enum logic [2:0] {S_IDLE, S_COF, S_DET, S_SCALE, S_COMMIT} state_t;

  state_t             state;
  logic [3:0]         cnt;
  logic               valid;
  hc3_pkg::letter_t   km  [9];
  hc3_pkg::letter_t   adj [9];
  logic [9:0]         p_pos;
  logic [9:0]         p_neg;
  hc3_pkg::letter_t   det_acc;
  hc3_pkg::letter_t   det_next;
  hc3_pkg::letter_t   dinv;
  hc3_pkg::cof_idx_t  ci;
  logic [9:0]         det_prod;
  logic [9:0]         scale_prod;
  logic [3:0]         det_col;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      km[i] = hc3_pkg::reduce_letter(key_rows[i / 3][5 * (i % 3) +: 5]);
    end
    ci         = hc3_pkg::cof_index(cnt);
    det_col    = 4'(cnt[1:0]) * 4'd3;
    det_prod   = 10'(km[4'(cnt[1:0])]) * 10'(adj[det_col]);
    det_next   = hc3_pkg::mod26(12'(det_acc) + 12'(det_prod));
    scale_prod = 10'(adj[cnt]) * 10'(dinv);
  end

  assign status.busy  = (state != S_IDLE);
  assign status.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= 4'd0;
      valid   <= 1'b1;
      inv_key <= hc3_pkg::INV_RESET;
    end else if (start) begin
      state <= S_COF;
      cnt   <= 4'd0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= 4'd0;
        end
        S_COF: begin
          if (cnt < 4'd9) begin
            p_pos <= 10'(km[ci.a0]) * 10'(km[ci.a1]);
            p_neg <= 10'(km[ci.b0]) * 10'(km[ci.b1]);
          end
          if (cnt != 4'd0) begin
            adj[cnt - 4'd1] <= hc3_pkg::mod26(12'(p_pos)
                               + 12'(hc3_pkg::MODULUS * hc3_pkg::MODULUS) - 12'(p_neg));
          end
          if (cnt == 4'd9) begin
            state   <= S_DET;
            cnt     <= 4'd0;
            det_acc <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_DET: begin
          det_acc <= det_next;
          if (cnt == 4'd2) begin
            dinv  <= hc3_pkg::det_inverse(det_next);
            state <= S_SCALE;
            cnt   <= 4'd0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_SCALE: begin
          adj[cnt] <= hc3_pkg::mod26(12'(scale_prod));
          if (cnt == 4'd8) begin
            state <= S_COMMIT;
            cnt   <= 4'd0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_COMMIT: begin
          if (dinv != '0) begin
            valid <= 1'b1;
            for (int i = 0; i < 9; i++) begin
              inv_key[i] <= adj[i];
            end
          end else begin
            valid <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/hc3_back.sv */
// ----------------------------------------------------------------------------
// hc3_back
// Takes one row of the key or its inverse per cycle against the head block
// while the output queue has room, and queues each dot product mod 26.
// ----------------------------------------------------------------------------
module hc3_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  hc3_pkg::block_t    q_head,
  output logic               q_pop,
  input  hc3_pkg::key_rows_t key_rows,
  input  hc3_pkg::matrix_t   inv_key,
  input  logic               decrypt,
  input  logic               inv_valid,
  input  logic               pop,
  output logic               empty,
  output hc3_pkg::result_t   head
);

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);

  logic [1:0]        row;
  logic              issue;
  logic              err;
  hc3_pkg::letter_t  kv [3];
  hc3_pkg::letter_t  bl [3];
  logic [9:0]        prod [3];
  logic [10:0]       sum_next;
  logic              s1_valid;
  logic [10:0]       s1_sum;
  logic              s1_bend;
  logic              s1_mend;
  logic              s1_err;
  hc3_pkg::result_t  wr_item;
  hc3_pkg::result_t  mem [OUT_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W:0]    ocount;
  logic              do_pop;

  assign err    = decrypt && !inv_valid;
  assign issue  = !q_empty && ((32'(ocount) + 32'(s1_valid)) < OUT_DEPTH);
  assign q_pop  = issue && (row == 2'd2);
  assign empty  = (ocount == '0);
  assign head   = mem[rptr];
  assign do_pop = pop && !empty;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      bl[j]   = hc3_pkg::reduce_letter(q_head.letters[j]);
      kv[j]   = decrypt ? inv_key[4'(row) * 4'd3 + 4'(j)]
                        : hc3_pkg::reduce_letter(key_rows[row][5 * j +: 5]);
      prod[j] = 10'(kv[j]) * 10'(bl[j]);
    end
    sum_next = 11'(prod[0]) + 11'(prod[1]) + 11'(prod[2]);
    wr_item.letter      = s1_err ? '0 : hc3_pkg::mod26(12'(s1_sum));
    wr_item.block_end   = s1_bend;
    wr_item.message_end = s1_mend;
    wr_item.key_error   = s1_err;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sum  <= sum_next;
      s1_bend <= (row == 2'd2);
      s1_mend <= (row == 2'd2) && q_head.last;
      s1_err  <= err;
    end
    if (s1_valid) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= 2'd0;
      s1_valid <= 1'b0;
      wptr     <= '0;
      rptr     <= '0;
      ocount   <= '0;
    end else begin
      s1_valid <= issue;
      if (issue) begin
        row <= (row == 2'd2) ? 2'd0 : row + 2'd1;
      end
      if (s1_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      ocount <= ocount + (PTR_W + 1)'(s1_valid) - (PTR_W + 1)'(do_pop);
    end
  end

endmodule

/* rtl/core/hill_cipher_3x3_mod26_unit.sv */
// ----------------------------------------------------------------------------
// hill_cipher_3x3_mod26_unit
// Hill cipher over 26 letters with a 3x3 key; blocks of three letters are
// multiplied by the key or its mod-26 inverse.
//
//   channel  direction  handshake         payload
//   input    in         push / full       in_letter, in_last
//   result   out        empty / pop       out_letter, block_end, message_end,
//                                         key_error
//   config   in         cfg_write         cfg_index, cfg_data
//
// one letter accepted per cycle while full is low; each block gives three
// results, one per cycle from the row unit while the result queue has room.
// a key row write starts an inverse pass (9 cofactors, 3 determinant terms,
// 9 scaling products), during which full is high.
// reset is synchronous; the inverse of the reset key is loaded directly.
// a stalled result side fills the 4-entry result queue and the 2-entry block
// queue, then full rises.
// ----------------------------------------------------------------------------
module hill_cipher_3x3_mod26_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  in_letter,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_letter,
  output logic        block_end,
  output logic        message_end,
  output logic        key_error,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  hc3_pkg::key_rows_t   key_rows;
  logic                 cipher_mode;
  logic                 key_write;
  logic                 stall;
  hc3_pkg::inv_status_t inv_status;
  hc3_pkg::matrix_t     inv_key;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  hc3_pkg::block_t      q_block;
  hc3_pkg::block_t      q_head;
  hc3_pkg::result_t     result;

  assign key_write = cfg_write && (cfg_index != hc3_pkg::REG_CIPHER_MODE);
  assign stall     = inv_status.busy || key_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rows    <= hc3_pkg::KEY_RESET;
      cipher_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        hc3_pkg::REG_KEY_ROW_0:   key_rows[0] <= cfg_data;
        hc3_pkg::REG_KEY_ROW_1:   key_rows[1] <= cfg_data;
        hc3_pkg::REG_KEY_ROW_2:   key_rows[2] <= cfg_data;
        hc3_pkg::REG_CIPHER_MODE: cipher_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  hc3_inverse u_inverse (
    .clk      (clk),
    .rst      (rst),
    .start    (key_write),
    .key_rows (key_rows),
    .inv_key  (inv_key),
    .status   (inv_status)
  );

  hc3_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .letter  (in_letter),
    .last    (in_last),
    .stall   (stall),
    .q_full  (q_full),
    .full    (full),
    .q_push  (q_push),
    .q_block (q_block)
  );

  hc3_block_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_block),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  hc3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .key_rows  (key_rows),
    .inv_key   (inv_key),
    .decrypt   (cipher_mode),
    .inv_valid (inv_status.valid),
    .pop       (pop),
    .empty     (empty),
    .head      (result)
  );

  assign out_letter  = result.letter;
  assign block_end   = result.block_end;
  assign message_end = result.message_end;
  assign key_error   = result.key_error;

  // no item enters while the inverse key is being rebuilt
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !inv_status.busy)
    else $error("item accepted during inverse pass");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && key_error) |-> (out_letter == 5'd0))
    else $error("key error result carries a nonzero letter");

  a_msg_end_block: assert property (@(posedge clk) disable iff (rst)
    (!empty && message_end) |-> block_end)
    else $error("message end outside a block end");

  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_letter < 5'd26))
    else $error("result letter out of range");

endmodule

/* dv/hill_cipher_3x3_mod26_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_3x3_mod26_unit_tb
// Streams letters into the 3x3 hill cipher unit in encrypt and decrypt mode,
// under the reset key, extreme keys, singular keys and random keys. A local
// model of the cipher predicts every result letter and its flags, and each
// result popped from the unit is compared against the oldest prediction.
// Both handshakes idle at random except while no_idle is set.
// ----------------------------------------------------------------------------
module hill_cipher_3x3_mod26_unit_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [14:0] key_set_t [3];
  typedef int inv_set_t [3][3];

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [4:0]  in_letter;
  logic        in_last;
  logic        empty;
  logic        pop;
  logic [4:0]  out_letter;
  logic        block_end;
  logic        message_end;
  logic        key_error;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  key_set_t    key_rows;
  bit          decrypt_mode;
  logic [4:0]  open_letters [2];
  int          open_count;
  inv_set_t    inv_matrix;
  bit          inv_ok;

  hc3_pkg::result_t expected_letters_q [$];
  hc3_pkg::result_t exp_res;
  int          mismatch_count;
  int          cycle_count;
  int          pop_wait;
  bit          no_idle;

  hill_cipher_3x3_mod26_unit dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_letter   (in_letter),
    .in_last     (in_last),
    .empty       (empty),
    .pop         (pop),
    .out_letter  (out_letter),
    .block_end   (block_end),
    .message_end (message_end),
    .key_error   (key_error),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int wrap26(input int v);
    return ((v % 26) + 26) % 26;
  endfunction

  function automatic int key_entry(input key_set_t rows, input int r, input int c);
    return int'(rows[r][5*c +: 5]) % 26;
  endfunction

  // adjugate times determinant inverse; returns 0 when no inverse exists
  function automatic bit invert_key(input key_set_t rows, output inv_set_t inv);
    int k [3][3];
    int adj [3][3];
    int det;
    int dinv;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        k[r][c] = key_entry(rows, r, c);
    adj[0][0] =  (k[1][1] * k[2][2] - k[1][2] * k[2][1]);
    adj[0][1] = -(k[0][1] * k[2][2] - k[0][2] * k[2][1]);
    adj[0][2] =  (k[0][1] * k[1][2] - k[0][2] * k[1][1]);
    adj[1][0] = -(k[1][0] * k[2][2] - k[1][2] * k[2][0]);
    adj[1][1] =  (k[0][0] * k[2][2] - k[0][2] * k[2][0]);
    adj[1][2] = -(k[0][0] * k[1][2] - k[0][2] * k[1][0]);
    adj[2][0] =  (k[1][0] * k[2][1] - k[1][1] * k[2][0]);
    adj[2][1] = -(k[0][0] * k[2][1] - k[0][1] * k[2][0]);
    adj[2][2] =  (k[0][0] * k[1][1] - k[0][1] * k[1][0]);
    det = wrap26(k[0][0] * adj[0][0] + k[0][1] * adj[1][0] + k[0][2] * adj[2][0]);
    dinv = 0;
    for (int c = 1; c < 26; c++)
      if (dinv == 0 && (det * c) % 26 == 1) dinv = c;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        inv[r][c] = wrap26(wrap26(adj[r][c]) * dinv);
    return dinv != 0;
  endfunction

  // singular key keeps the old inverse
  function automatic void refresh_inverse_key();
    inv_set_t scratch;
    inv_ok = invert_key(key_rows, scratch);
    if (inv_ok) inv_matrix = scratch;
  endfunction

  function automatic void reset_cipher_model();
    for (int r = 0; r < 3; r++) key_rows[r] = hc3_pkg::KEY_RESET[r];
    decrypt_mode = 1'b0;
    open_letters[0] = '0;
    open_letters[1] = '0;
    open_count = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        inv_matrix[r][c] = 0;
    refresh_inverse_key();
  endfunction

  function automatic void absorb_letter(input logic [4:0] letter, input bit last);
    logic [4:0] blk [3];
    bit err;
    int acc;
    int kv;
    hc3_pkg::result_t res;
    if (open_count < 2 && !last) begin
      open_letters[open_count] = letter;
      open_count++;
      return;
    end
    for (int i = 0; i < 3; i++) blk[i] = hc3_pkg::PAD_LETTER;
    for (int i = 0; i < open_count; i++) blk[i] = open_letters[i];
    blk[open_count] = letter;
    open_count = 0;
    open_letters[0] = '0;
    open_letters[1] = '0;
    err = decrypt_mode && !inv_ok;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        kv = decrypt_mode ? inv_matrix[i][j] : key_entry(key_rows, i, j);
        acc += kv * (int'(blk[j]) % 26);
      end
      res.letter      = err ? 5'd0 : 5'(acc % 26);
      res.block_end   = (i == 2);
      res.message_end = (i == 2) && last;
      res.key_error   = err;
      expected_letters_q.push_back(res);
    end
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // result side
  always @(negedge clk) begin
    if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait--;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      pop_wait = draw_wait();
      if (expected_letters_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: letter %0d be %0b me %0b ke %0b",
                   out_letter, block_end, message_end, key_error);
      end else begin
        exp_res = expected_letters_q.pop_front();
        if (out_letter !== exp_res.letter || block_end !== exp_res.block_end ||
            message_end !== exp_res.message_end || key_error !== exp_res.key_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected letter %0d be %0b me %0b ke %0b, got %0d %0b %0b %0b",
                     exp_res.letter, exp_res.block_end, exp_res.message_end,
                     exp_res.key_error, out_letter, block_end, message_end, key_error);
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_letter(input logic [4:0] letter, input bit last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    in_letter <= letter;
    in_last   <= last;
    do @(posedge clk); while (full);
    absorb_letter(letter, last);
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    push <= 1'b0;
    while (expected_letters_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [14:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      hc3_pkg::REG_KEY_ROW_0: begin
        key_rows[0] = data;
        refresh_inverse_key();
      end
      hc3_pkg::REG_KEY_ROW_1: begin
        key_rows[1] = data;
        refresh_inverse_key();
      end
      hc3_pkg::REG_KEY_ROW_2: begin
        key_rows[2] = data;
        refresh_inverse_key();
      end
      default: decrypt_mode = data[0];
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    repeat (2) @(negedge clk);
    while (full) @(negedge clk);
  endtask

  task automatic write_key(input logic [14:0] r0, input logic [14:0] r1,
                           input logic [14:0] r2);
    write_register(hc3_pkg::REG_KEY_ROW_0, r0);
    write_register(hc3_pkg::REG_KEY_ROW_1, r1);
    write_register(hc3_pkg::REG_KEY_ROW_2, r2);
  endtask

  // extreme and out-of-range letters, padding of two, one and no letters
  task automatic test_encrypt_reset_key();
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b0);
    send_letter(5'd13, 1'b0);
    send_letter(5'd7, 1'b1);
    send_letter(5'd25, 1'b1);
    send_letter(5'd4, 1'b0);
    send_letter(5'd5, 1'b1);
  endtask

  task automatic test_decrypt_reset_key();
    wait_for_idle();
    write_register(hc3_pkg::REG_CIPHER_MODE, 15'd1);
    send_letter(5'd7, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd11, 1'b0);
    send_letter(5'd11, 1'b0);
    send_letter(5'd14, 1'b1);
  endtask

  // zero row makes the key singular
  task automatic test_singular_key();
    wait_for_idle();
    write_key(15'd0, 15'd26425, 15'h7fff);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd3, 1'b0);
    wait_for_idle();
    write_register(hc3_pkg::REG_CIPHER_MODE, 15'd0);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b1);
  endtask

  // out-of-range key entries, and a mode change with a block open
  task automatic test_mode_switch_open_block();
    wait_for_idle();
    write_key(15'h7fff, 15'h7fff, 15'h7fff);
    send_letter(5'd30, 1'b0);
    send_letter(5'd17, 1'b0);
    send_letter(5'd9, 1'b0);
    wait_for_idle();
    write_key(15'd27, 15'd27 << 5, 15'd27 << 10);
    send_letter(5'd8, 1'b0);
    send_letter(5'd19, 1'b0);
    wait_for_idle();
    write_register(hc3_pkg::REG_CIPHER_MODE, 15'd1);
    send_letter(5'd22, 1'b1);
  endtask

  function automatic logic [14:0] random_key_row();
    if ($urandom_range(0, 3) == 0) return 15'($urandom_range(0, 32767));
    return {5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
            5'($urandom_range(0, 25))};
  endfunction

  task automatic test_random_stream();
    key_set_t cand;
    inv_set_t scratch;
    bit want_inv;
    logic [4:0] letter;
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_idle();
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        want_inv = $urandom_range(0, 3) != 0;
        for (int tries = 0; tries < 200; tries++) begin
          for (int r = 0; r < 3; r++) cand[r] = random_key_row();
          if (invert_key(cand, scratch) == want_inv) break;
        end
        write_key(cand[0], cand[1], cand[2]);
      end
      write_register(hc3_pkg::REG_CIPHER_MODE, 15'($urandom_range(0, 1)));
      no_idle = (phase % 3 == 2);
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(0, 9) == 0) letter = 5'($urandom_range(26, 31));
        else letter = 5'($urandom_range(0, 25));
        send_letter(letter, $urandom_range(0, 7) == 0);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    push           = 1'b0;
    in_letter      = '0;
    in_last        = 1'b0;
    pop            = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    pop_wait       = 0;
    no_idle        = 1'b0;
    reset_cipher_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (full) @(negedge clk);

    test_encrypt_reset_key();
    test_decrypt_reset_key();
    test_singular_key();
    test_mode_switch_open_block();
    test_random_stream();

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_letters_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
